FILE: rtl/core/bffa_pkg.sv
// ----------------------------------------------------------------------------
// bffa_pkg
// Shared constants, payload types and control structs of the bitmap
// first-fit block allocator.
// ----------------------------------------------------------------------------
package bffa_pkg;

  localparam int MAX_BLOCKS  = 512;
  localparam int BLOCK_BYTES = 8;
  localparam int BLOCK_SHIFT = $clog2(BLOCK_BYTES);

  localparam int ROW_BITS  = 8;
  localparam int ROW_SHIFT = $clog2(ROW_BITS);
  localparam int ROWS      = MAX_BLOCKS / ROW_BITS;
  localparam int ROW_AW    = $clog2(ROWS);
  localparam int BLK_AW    = $clog2(MAX_BLOCKS);
  localparam int NUM_W     = BLK_AW + 1;

  localparam int OFFSET_W = 12;
  localparam int BYTES_W  = 13;
  localparam int CFG_W    = 10;
  localparam int STATUS_W = 2;
  localparam int FREE_W   = 10;
  localparam int CNT_W    = BYTES_W - BLOCK_SHIFT + 1;

  typedef logic [STATUS_W-1:0] status_t;

  localparam status_t ST_OK       = status_t'(0);
  localparam status_t ST_NO_ROOM  = status_t'(1);
  localparam status_t ST_BAD_SIZE = status_t'(2);

  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  typedef struct packed {
    logic                mode;
    logic [OFFSET_W-1:0] byte_offset;
    logic [BYTES_W-1:0]  byte_count;
  } req_t;

  typedef struct packed {
    status_t             status;
    logic [OFFSET_W-1:0] region_offset;
    logic [FREE_W-1:0]   free_blocks;
  } rsp_t;

  typedef struct packed {
    logic    accept;
    logic    scan_start;
    logic    scan_en;
    logic    upd_start;
    logic    upd_en;
    logic    load_out;
    logic    commit_alloc;
    logic    commit_free;
    status_t status;
  } cmd_t;

  typedef struct packed {
    logic bad_size;
    logic no_room;
    logic mode_free;
    logic free_in_range;
    logic found;
    logic row_last;
  } sts_t;

  function automatic logic [NUM_W-1:0] eff_blocks(input logic [CFG_W-1:0] cfg);
    logic [NUM_W-1:0] n;
    if (cfg == '0) begin
      n = NUM_W'(1);
    end else if (cfg > MAX_BLOCKS) begin
      n = NUM_W'(MAX_BLOCKS);
    end else begin
      n = NUM_W'(cfg);
    end
    return n;
  endfunction

endpackage

FILE: rtl/core/bitmap_first_fit_block_allocator_top.sv
// ----------------------------------------------------------------------------
// bitmap_first_fit_block_allocator_top
// First-fit contiguous allocator over one bucket of 8-byte blocks, kept as a
// usage bitmap in RAM, one 8-block row per word.
// ----------------------------------------------------------------------------
// One transaction at a time. A request is accepted in S_IDLE and checked in
// S_CHECK, then an allocation scans bitmap rows from row 0 at one row per
// cycle (up to 64 rows) and marks the found run at one row per cycle, and a
// free clears its rows the same way; S_FINISH then loads the result register,
// the pace being set by the single read port of the bitmap RAM. The next
// request is taken while a result still waits on out_stall. A write to the
// block count register clears the bucket through per-row valid flags, so no
// clearing pass follows reset or configuration.
module bitmap_first_fit_block_allocator_top
  import bffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  req_t             in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output rsp_t             out_data
);

  cmd_t cmd;
  sts_t sts;

  bffa_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  bffa_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_rsp   (out_data)
  );

endmodule

FILE: rtl/core/bffa_ram.sv
// ----------------------------------------------------------------------------
// bffa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: rtl/core/bffa_dp.sv
// ----------------------------------------------------------------------------
// bffa_dp
// Datapath: block count register, free counter, bitmap RAM with row valid
// flags, row scanner for first fit, row read-modify-write and result register.
// ----------------------------------------------------------------------------
module bffa_dp
  import bffa_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_wr_en,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  req_t             in_req,
  input  cmd_t             cmd,
  output sts_t             sts,
  output rsp_t             out_rsp
);

  logic [CFG_W-1:0]   cfg_r;
  logic [NUM_W-1:0]   free_r;
  logic [NUM_W-1:0]   free_nxt;
  logic [ROWS-1:0]    row_valid_r;

  logic               mode_r;
  logic [CNT_W-1:0]   count_r;
  logic               bad_r;
  logic               noroom_r;
  logic [BLK_AW-1:0]  sfree_r;

  logic [ROW_AW-1:0]  rd_row_r;
  logic [ROW_AW-1:0]  lim_row_r;
  logic [ROW_AW-1:0]  dat_row_r;
  logic               issue_done_r;
  logic               dat_pend_r;
  logic               rd_vld_r;
  logic [NUM_W-1:0]   run_r;
  logic [BLK_AW-1:0]  lo_r;
  logic [BLK_AW-1:0]  hi_r;
  rsp_t               rsp_r;

  logic [NUM_W-1:0]    n;
  logic [BLK_AW-1:0]   last_blk;
  logic [BYTES_W:0]    bytes_sum;
  logic [CNT_W-1:0]    count_in;
  logic [ROW_BITS-1:0] ram_rdata;
  logic [ROW_BITS-1:0] row_data;
  logic [ROW_BITS-1:0] mask;
  logic [ROW_BITS-1:0] new_row;
  logic [NUM_W-1:0]    run_c;
  logic                found_c;
  logic [BLK_AW-1:0]   fend_c;
  logic [BLK_AW-1:0]   start_c;
  logic [CNT_W-1:0]    free_end;
  logic [BLK_AW-1:0]   hi_free;
  logic [CNT_W-1:0]    free_sum;
  logic                issue_en;
  logic                scan_hit;
  logic                ram_we;

  assign n        = eff_blocks(cfg_r);
  assign last_blk = BLK_AW'(n - NUM_W'(1));

  assign bytes_sum = {1'b0, in_req.byte_count} + (BYTES_W + 1)'(BLOCK_BYTES - 1);
  assign count_in  = bytes_sum[BYTES_W:BLOCK_SHIFT];

  assign row_data = rd_vld_r ? ram_rdata : '0;

  always_comb begin
    run_c   = run_r;
    found_c = 1'b0;
    fend_c  = '0;
    for (int j = 0; j < ROW_BITS; j++) begin
      if (NUM_W'({dat_row_r, ROW_SHIFT'(j)}) < n) begin
        if (row_data[j]) begin
          run_c = '0;
        end else begin
          run_c = run_c + NUM_W'(1);
        end
        if (!found_c && (CNT_W'(run_c) >= count_r)) begin
          found_c = 1'b1;
          fend_c  = {dat_row_r, ROW_SHIFT'(j)};
        end
      end
    end
  end

  assign start_c = BLK_AW'(CNT_W'(fend_c) + CNT_W'(1) - count_r);

  assign free_end = CNT_W'(sfree_r) + count_r - CNT_W'(1);
  assign hi_free  = (free_end > CNT_W'(last_blk)) ? last_blk : free_end[BLK_AW-1:0];

  always_comb begin
    for (int j = 0; j < ROW_BITS; j++) begin
      mask[j] = ({dat_row_r, ROW_SHIFT'(j)} >= lo_r) && ({dat_row_r, ROW_SHIFT'(j)} <= hi_r);
    end
  end

  assign new_row = (mode_r == MODE_FREE) ? (row_data & ~mask) : (row_data | mask);

  assign issue_en = (cmd.scan_en || cmd.upd_en) && !issue_done_r;
  assign scan_hit = cmd.scan_en && dat_pend_r && found_c;
  assign ram_we   = cmd.upd_en && dat_pend_r;

  bffa_ram #(
    .WIDTH (ROW_BITS),
    .DEPTH (ROWS)
  ) u_bitmap (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dat_row_r),
    .wdata (new_row),
    .re    (issue_en),
    .raddr (rd_row_r),
    .rdata (ram_rdata)
  );

  assign free_sum = CNT_W'(free_r) + count_r;

  always_comb begin
    free_nxt = free_r;
    if (cmd.commit_alloc) begin
      free_nxt = free_r - NUM_W'(count_r);
    end else if (cmd.commit_free) begin
      free_nxt = (free_sum > CNT_W'(n)) ? n : NUM_W'(free_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_W'(MAX_BLOCKS);
      free_r       <= NUM_W'(MAX_BLOCKS);
      row_valid_r  <= '0;
      issue_done_r <= 1'b1;
      dat_pend_r   <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        cfg_r       <= cfg_wdata;
        free_r      <= eff_blocks(cfg_wdata);
        row_valid_r <= '0;
      end else begin
        if (ram_we) begin
          row_valid_r[dat_row_r] <= 1'b1;
        end
        if (cmd.load_out) begin
          free_r <= free_nxt;
        end
      end

      dat_pend_r <= issue_en && !scan_hit;
      if (cmd.scan_start) begin
        issue_done_r <= 1'b0;
      end else if (cmd.upd_start) begin
        issue_done_r <= 1'b0;
      end else if (scan_hit) begin
        issue_done_r <= 1'b0;
      end else if (issue_en && (rd_row_r == lim_row_r)) begin
        issue_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      mode_r   <= in_req.mode;
      count_r  <= count_in;
      bad_r    <= (in_req.byte_count == '0) || (count_in > CNT_W'(n));
      noroom_r <= CNT_W'(free_r) < count_in;
      sfree_r  <= in_req.byte_offset[OFFSET_W-1:BLOCK_SHIFT];
    end

    if (cmd.scan_start) begin
      rd_row_r  <= '0;
      lim_row_r <= last_blk[BLK_AW-1:ROW_SHIFT];
    end else if (cmd.upd_start) begin
      lo_r      <= sfree_r;
      hi_r      <= hi_free;
      rd_row_r  <= sfree_r[BLK_AW-1:ROW_SHIFT];
      lim_row_r <= hi_free[BLK_AW-1:ROW_SHIFT];
    end else if (scan_hit) begin
      lo_r      <= start_c;
      hi_r      <= fend_c;
      rd_row_r  <= start_c[BLK_AW-1:ROW_SHIFT];
      lim_row_r <= fend_c[BLK_AW-1:ROW_SHIFT];
    end else if (issue_en) begin
      rd_row_r <= rd_row_r + ROW_AW'(1);
    end

    if (cmd.scan_start) begin
      run_r <= '0;
    end else if (cmd.scan_en && dat_pend_r) begin
      run_r <= run_c;
    end

    if (issue_en) begin
      dat_row_r <= rd_row_r;
      rd_vld_r  <= row_valid_r[rd_row_r];
    end

    if (cmd.load_out) begin
      rsp_r.status        <= cmd.status;
      rsp_r.region_offset <= cmd.commit_alloc ? (OFFSET_W'(lo_r) << BLOCK_SHIFT) : '0;
      rsp_r.free_blocks   <= FREE_W'(free_nxt);
    end
  end

  assign sts.bad_size      = bad_r;
  assign sts.no_room       = noroom_r;
  assign sts.mode_free     = (mode_r == MODE_FREE);
  assign sts.free_in_range = NUM_W'(sfree_r) < n;
  assign sts.found         = dat_pend_r && found_c;
  assign sts.row_last      = dat_pend_r && (dat_row_r == lim_row_r);

  assign out_rsp = rsp_r;

endmodule

FILE: rtl/core/bffa_ctrl.sv
// ----------------------------------------------------------------------------
// bffa_ctrl
// Controller: sequences check, first-fit scan, bitmap update and result
// hand-off; owns the input stall and the output valid.
// ----------------------------------------------------------------------------
module bffa_ctrl
  import bffa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_CHECK  = 5'b00010,
    S_SCAN   = 5'b00100,
    S_UPDATE = 5'b01000,
    S_FINISH = 5'b10000
  } state_t;

  state_t  state_r;
  state_t  state_nxt;
  status_t stat_r;
  status_t stat_nxt;
  logic    out_valid_r;
  logic    out_valid_nxt;

  always_comb begin
    state_nxt  = state_r;
    stat_nxt   = stat_r;
    cmd        = '0;
    cmd.status = stat_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = S_CHECK;
        end
      end
      S_CHECK: begin
        stat_nxt = ST_OK;
        if (sts.bad_size) begin
          stat_nxt  = ST_BAD_SIZE;
          state_nxt = S_FINISH;
        end else if (!sts.mode_free) begin
          if (sts.no_room) begin
            stat_nxt  = ST_NO_ROOM;
            state_nxt = S_FINISH;
          end else begin
            cmd.scan_start = 1'b1;
            state_nxt      = S_SCAN;
          end
        end else if (sts.free_in_range) begin
          cmd.upd_start = 1'b1;
          state_nxt     = S_UPDATE;
        end else begin
          state_nxt = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_en = 1'b1;
        if (sts.found) begin
          state_nxt = S_UPDATE;
        end else if (sts.row_last) begin
          stat_nxt  = ST_NO_ROOM;
          state_nxt = S_FINISH;
        end
      end
      S_UPDATE: begin
        cmd.upd_en = 1'b1;
        if (sts.row_last) begin
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          cmd.load_out     = 1'b1;
          cmd.commit_alloc = (stat_r == ST_OK) && !sts.mode_free;
          cmd.commit_free  = (stat_r == ST_OK) && sts.mode_free;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      stat_r      <= ST_OK;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      stat_r      <= stat_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bitmap first-fit block allocator. A bucket
// model in the bench (usage bitmap, free counter, block count register)
// predicts every response when its request is accepted. Responses are checked
// field by field in order. Directed corner cases and bucket size sweeps come
// first, then random allocate/free traffic under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_top;
  import bffa_pkg::*;

  localparam int HALF_PERIOD    = 5;
  localparam int RESET_CYCLES   = 10;
  localparam int SETTLE_CYCLES  = 8;
  localparam int TAIL_CYCLES    = 200;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int PHASE_ITEMS    = 450;
  localparam int MAX_REPORTS    = 10;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             cfg_wr_en = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  req_t             in_data = '0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  rsp_t             out_data;

  bit [MAX_BLOCKS-1:0] blk_used;
  int                  free_cnt;
  logic [CFG_W-1:0]    bucket_cfg;
  rsp_t                rsp_pending[$];

  int gap_pct = 0;
  int stall_pct = 0;
  int err_cnt = 0;
  int quiet_cycles = 0;

  bitmap_first_fit_block_allocator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  always #HALF_PERIOD clk = ~clk;

  function automatic int bucket_blocks();
    int n;
    n = int'(bucket_cfg);
    if (n < 1) n = 1;
    if (n > MAX_BLOCKS) n = MAX_BLOCKS;
    return n;
  endfunction

  function automatic void reset_bucket(input logic [CFG_W-1:0] size);
    bucket_cfg = size;
    blk_used   = '0;
    free_cnt   = bucket_blocks();
  endfunction

  function automatic rsp_t serve_request(input req_t r);
    rsp_t rsp;
    int   n;
    int   cnt;
    int   start;
    int   run;
    int   i;
    rsp   = '0;
    n     = bucket_blocks();
    cnt   = (int'(r.byte_count) + BLOCK_BYTES - 1) / BLOCK_BYTES;
    start = n;
    run   = 0;
    if (r.byte_count == '0 || cnt > n) begin
      rsp.status = ST_BAD_SIZE;
    end else if (r.mode == MODE_ALLOC) begin
      if (free_cnt >= cnt) begin
        for (i = 0; i < n && start == n; i++) begin
          if (blk_used[i]) begin
            run = 0;
          end else begin
            run++;
            if (run >= cnt) start = i + 1 - cnt;
          end
        end
      end
      if (start >= n) begin
        rsp.status = ST_NO_ROOM;
      end else begin
        for (i = start; i < start + cnt; i++) blk_used[i] = 1'b1;
        free_cnt -= cnt;
        rsp.status = ST_OK;
        rsp.region_offset = OFFSET_W'(start * BLOCK_BYTES);
      end
    end else begin
      start = int'(r.byte_offset) / BLOCK_BYTES;
      for (i = start; i < start + cnt; i++) begin
        if (i < n) blk_used[i] = 1'b0;
      end
      free_cnt += cnt;
      if (free_cnt > n) free_cnt = n;
      rsp.status = ST_OK;
    end
    rsp.free_blocks = FREE_W'(free_cnt);
    return rsp;
  endfunction

  function automatic req_t mk_req(input logic mode, input int offset, input int bytes);
    req_t r;
    r.mode        = mode;
    r.byte_offset = OFFSET_W'(offset);
    r.byte_count  = BYTES_W'(bytes);
    return r;
  endfunction

  function automatic req_t random_req();
    req_t r;
    int   sel;
    int   n;
    int   pick;
    int   blk;
    int   k;
    n    = bucket_blocks();
    sel  = $urandom_range(0, 99);
    r    = mk_req(MODE_ALLOC, $urandom_range(0, 4095), 0);
    if (sel < 45) begin
      sel = $urandom_range(0, 99);
      if (sel < 70) r.byte_count = BYTES_W'($urandom_range(1, 64));
      else if (sel < 90) r.byte_count = BYTES_W'($urandom_range(1, n * BLOCK_BYTES));
      else r.byte_count = BYTES_W'($urandom_range(0, 8191));
    end else if (sel < 85) begin
      pick = $urandom_range(0, n - 1);
      blk  = pick;
      for (k = 0; k < n; k++) begin
        if (blk_used[(pick + k) % n]) begin
          blk = (pick + k) % n;
          break;
        end
      end
      r.mode        = MODE_FREE;
      r.byte_offset = OFFSET_W'(blk * BLOCK_BYTES + $urandom_range(0, BLOCK_BYTES - 1));
      if ($urandom_range(0, 9) < 8) begin
        r.byte_count = BYTES_W'($urandom_range(1, BLOCK_BYTES * $urandom_range(1, 8)));
      end else begin
        r.byte_count = BYTES_W'($urandom_range(1, n * BLOCK_BYTES));
      end
    end else begin
      r.mode        = 1'($urandom_range(0, 1));
      r.byte_offset = OFFSET_W'($urandom_range(0, 4095));
      r.byte_count  = BYTES_W'($urandom_range(0, 8191));
    end
    return r;
  endfunction

  always @(negedge clk) begin
    out_stall = ($urandom_range(0, 99) < stall_pct);
  end

  always @(posedge clk) begin
    rsp_t exp_rsp;
    logic bad;
    if (!rst_n) begin
      reset_bucket(CFG_W'(MAX_BLOCKS));
      rsp_pending.delete();
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (cfg_wr_en) reset_bucket(cfg_wdata);
      if (in_valid && !in_stall) begin
        rsp_pending.push_back(serve_request(in_data));
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        quiet_cycles = 0;
        if (rsp_pending.size() == 0) begin
          err_cnt++;
          if (err_cnt <= MAX_REPORTS) begin
            $display("ERROR %0t: unexpected response status=%0d offset=%0d free=%0d",
                     $realtime, out_data.status, out_data.region_offset,
                     out_data.free_blocks);
          end
        end else begin
          exp_rsp = rsp_pending.pop_front();
          bad = 1'b0;
          if (out_data.status !== exp_rsp.status) bad = 1'b1;
          if (out_data.region_offset !== exp_rsp.region_offset) bad = 1'b1;
          if (out_data.free_blocks !== exp_rsp.free_blocks) bad = 1'b1;
          if (bad) begin
            err_cnt++;
            if (err_cnt <= MAX_REPORTS) begin
              $display("ERROR %0t: expected status=%0d offset=%0d free=%0d",
                       $realtime, exp_rsp.status, exp_rsp.region_offset,
                       exp_rsp.free_blocks);
              $display("        actual   status=%0d offset=%0d free=%0d",
                       out_data.status, out_data.region_offset, out_data.free_blocks);
            end
          end
        end
      end
    end
  end

  initial begin
    @(posedge rst_n);
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("FAIL bitmap_first_fit_block_allocator_top");
    $finish;
  end

  // Entered and left at a falling edge; valid stays high until the next call decides.
  task automatic send_req(input req_t r);
    while ($urandom_range(0, 99) < gap_pct) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid = 1'b0;
    while (rsp_pending.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_bucket_size(input logic [CFG_W-1:0] size);
    drain_results();
    cfg_wr_en = 1'b1;
    cfg_wdata = size;
    @(negedge clk);
    cfg_wr_en = 1'b0;
  endtask

  task automatic test_directed_cases();
    send_req(mk_req(MODE_ALLOC, 0, 0));
    send_req(mk_req(MODE_ALLOC, 4095, 1));
    send_req(mk_req(MODE_ALLOC, 0, 8));
    send_req(mk_req(MODE_ALLOC, 0, 9));
    send_req(mk_req(MODE_FREE, 4095, 0));
    send_req(mk_req(MODE_ALLOC, 0, 8191));
    send_req(mk_req(MODE_ALLOC, 0, 4097));
    send_req(mk_req(MODE_FREE, 4095, 8191));
    send_req(mk_req(MODE_ALLOC, 0, 4096));
    send_req(mk_req(MODE_FREE, 0, 4096));
    send_req(mk_req(MODE_ALLOC, 0, 4096));
    send_req(mk_req(MODE_ALLOC, 0, 1));
    send_req(mk_req(MODE_FREE, 3, 8));
    send_req(mk_req(MODE_FREE, 16, 8));
    send_req(mk_req(MODE_ALLOC, 0, 16));
    send_req(mk_req(MODE_FREE, 16, 8));
    send_req(mk_req(MODE_ALLOC, 0, 16));
    send_req(mk_req(MODE_FREE, 4088, 64));
    send_req(mk_req(MODE_ALLOC, 0, 8));
    send_req(mk_req(MODE_ALLOC, 0, 8));
    send_req(mk_req(MODE_ALLOC, 0, 8));
    send_req(mk_req(MODE_ALLOC, 0, 8));
    send_req(mk_req(MODE_FREE, 0, 4096));
    send_req(mk_req(MODE_ALLOC, 4095, 4096));
    drain_results();
  endtask

  task automatic test_bucket_sizes();
    logic [CFG_W-1:0] sizes[6];
    int               n;
    sizes = '{CFG_W'(0), CFG_W'(1), CFG_W'(1023), CFG_W'(513), CFG_W'(37),
              CFG_W'(MAX_BLOCKS)};
    foreach (sizes[s]) begin
      write_bucket_size(sizes[s]);
      n = bucket_blocks();
      send_req(mk_req(MODE_ALLOC, 0, 8));
      send_req(mk_req(MODE_ALLOC, 0, n * BLOCK_BYTES));
      send_req(mk_req(MODE_ALLOC, 0, n * BLOCK_BYTES + 1));
      send_req(mk_req(MODE_FREE, 0, n * BLOCK_BYTES));
      send_req(mk_req(MODE_ALLOC, 0, n * BLOCK_BYTES));
    end
    drain_results();
  endtask

  task automatic test_random_traffic(input logic [CFG_W-1:0] size, input int gap,
                                     input int stall);
    write_bucket_size(size);
    gap_pct   = gap;
    stall_pct = stall;
    for (int i = 0; i < PHASE_ITEMS; i++) begin
      if (i % 150 == 149) drain_results();
      send_req(random_req());
    end
    drain_results();
    gap_pct   = 0;
    stall_pct = 0;
  endtask

  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_cases();
    test_bucket_sizes();
    test_random_traffic(CFG_W'(MAX_BLOCKS), 0, 0);
    test_random_traffic(CFG_W'(40), 47, 0);
    test_random_traffic(CFG_W'($urandom_range(1, 511)), 0, 47);
    test_random_traffic(CFG_W'(1023), 35, 35);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_cnt == 0 && rsp_pending.size() == 0) begin
      $display("PASS bitmap_first_fit_block_allocator_top");
    end else begin
      $display("FAIL bitmap_first_fit_block_allocator_top");
    end
    $finish;
  end

endmodule
